// ----- hw/rtl/cdr_pkg.sv -----
// Shared constants, types and helper functions of the captive DNS responder.
package cdr_pkg;

   // Sizing of the packet store and of byte positions within a datagram.
   localparam int MAX_PACKET_BYTES_DEF = 304;
   localparam int POS_W                = 9;
   localparam int HEADER_BYTES         = 12;
   localparam int ANSWER_BYTES         = 16;
   localparam int LABEL_LIMIT          = 63;
   localparam logic [POS_W-1:0] POS_SATURATE = '1;
   localparam int QUESTION_TAIL        = 5;

   // Header positions that are checked or rewritten.
   localparam int QDCOUNT_HI_POS = 4;
   localparam int QDCOUNT_LO_POS = 5;
   localparam int FLAGS_HI_POS   = 2;
   localparam int FLAGS_LO_POS   = 3;
   localparam int ANCOUNT_HI_POS = 6;
   localparam int ANCOUNT_LO_POS = 7;

   localparam logic [7:0] FLAGS_HI   = 8'h81;
   localparam logic [7:0] FLAGS_LO   = 8'h80;
   localparam logic [7:0] ANCOUNT_HI = 8'h00;
   localparam logic [7:0] ANCOUNT_LO = 8'h01;

   // Answer record fields.
   localparam logic [15:0] NAME_POINTER = 16'hC00C;
   localparam logic [15:0] TYPE_A       = 16'h0001;
   localparam logic [15:0] CLASS_IN     = 16'h0001;
   localparam logic [15:0] RDATA_LENGTH = 16'h0004;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ANSWER_ADDRESS = 1'b0;
   localparam logic REG_ANSWER_TTL     = 1'b1;
   localparam logic [31:0] ANSWER_ADDRESS_RESET = 32'hC0A8_0401;
   localparam logic [31:0] ANSWER_TTL_RESET     = 32'd60;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_JUDGE,
      ST_FETCH,
      ST_SEND
   } reply_state_type;

   // Status of the datagram being received, from the intake to the reply logic.
   typedef struct packed {
      logic [POS_W-1:0] length;
      logic             accept;
      logic             final_taken;
   } parse_status_type;

   // Control from the reply logic back to the intake.
   typedef struct packed {
      logic intake_en;
      logic clear;
   } reply_ctrl_type;

   // Byte of the appended answer record at offset idx.
   function automatic logic [7:0] answer_byte(input logic [3:0]  idx,
                                              input logic [31:0] address,
                                              input logic [31:0] ttl);
      logic [7:0] b;
      case (idx)
         4'd0:    b = NAME_POINTER[15:8];
         4'd1:    b = NAME_POINTER[7:0];
         4'd2:    b = TYPE_A[15:8];
         4'd3:    b = TYPE_A[7:0];
         4'd4:    b = CLASS_IN[15:8];
         4'd5:    b = CLASS_IN[7:0];
         4'd6:    b = ttl[31:24];
         4'd7:    b = ttl[23:16];
         4'd8:    b = ttl[15:8];
         4'd9:    b = ttl[7:0];
         4'd10:   b = RDATA_LENGTH[15:8];
         4'd11:   b = RDATA_LENGTH[7:0];
         4'd12:   b = address[31:24];
         4'd13:   b = address[23:16];
         4'd14:   b = address[15:8];
         default: b = address[7:0];
      endcase
      return b;
   endfunction

endpackage

// ----- hw/rtl/cdr_if.sv -----
// Handshake channel interfaces for query bytes in and reply words out.
interface cdr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       final_byte;

   modport source (output valid, output packet_byte, output final_byte, input ready);
   modport sink   (input valid, input packet_byte, input final_byte, output ready);
endinterface

interface cdr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] reply_word;
   logic [3:0]  valid_bytes;
   logic        end_of_reply;
   logic        query_dropped;

   modport source (output valid, output reply_word, output valid_bytes,
                   output end_of_reply, output query_dropped, input ready);
   modport sink   (input valid, input reply_word, input valid_bytes,
                   input end_of_reply, input query_dropped, output ready);
endinterface

// ----- hw/rtl/cdr_csr.sv -----
// Configuration registers for the answer address and time to live.
module cdr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cdr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cdr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cdr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [31:0]                    answer_address,
   output logic [31:0]                    answer_ttl
);
   import cdr_pkg::*;

   logic [31:0] address_ff;
   logic [31:0] ttl_ff;
   logic        write_en;
   logic        reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= ANSWER_ADDRESS_RESET;
         ttl_ff     <= ANSWER_TTL_RESET;
      end else if (write_en) begin
         unique case (reg_index)
            REG_ANSWER_ADDRESS: address_ff <= csr_pwdata;
            REG_ANSWER_TTL:     ttl_ff     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ANSWER_ADDRESS: csr_prdata = address_ff;
         REG_ANSWER_TTL:     csr_prdata = ttl_ff;
         default:            csr_prdata = '0;
      endcase
   end

   assign answer_address = address_ff;
   assign answer_ttl     = ttl_ff;

endmodule

// ----- hw/rtl/cdr_store.sv -----
// Packet store: rows of eight bytes, one byte written and one row read per cycle.
module cdr_store #(
   parameter int MAX_PACKET_BYTES = cdr_pkg::MAX_PACKET_BYTES_DEF,
   localparam int ROWS  = (MAX_PACKET_BYTES + 7) / 8,
   localparam int ROW_W = $clog2(ROWS)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ROW_W-1:0] wr_row,
   input  logic [2:0]       wr_lane,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_row,
   output logic [63:0]      rd_data
);
   import cdr_pkg::*;

   logic [7:0] mem [ROWS][8];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_lane] <= wr_data;
      end
   end

   // Lane 0 holds the earliest byte and is read out in the top byte.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int k = 0; k < 8; k++) begin
            rd_data[63-8*k -: 8] <= mem[rd_row][k];
         end
      end
   end

endmodule

// ----- hw/rtl/cdr_parse.sv -----
// Byte intake: stores query bytes and follows the question name label by label.
module cdr_parse #(
   parameter int MAX_PACKET_BYTES = cdr_pkg::MAX_PACKET_BYTES_DEF,
   localparam int ROWS  = (MAX_PACKET_BYTES + 7) / 8,
   localparam int ROW_W = $clog2(ROWS)
) (
   input  logic                      clock,
   input  logic                      reset,
   cdr_req_if.sink                   req_chan,
   input  cdr_pkg::reply_ctrl_type   ctrl,
   output cdr_pkg::parse_status_type status,
   output logic                      wr_en,
   output logic [ROW_W-1:0]          wr_row,
   output logic [2:0]                wr_lane,
   output logic [7:0]                wr_data
);
   import cdr_pkg::*;

   logic [POS_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] label_pos_ff, label_pos_in;
   logic [POS_W-1:0] qend_ff, qend_in;
   logic             term_ff, term_in;
   logic             err_ff, err_in;
   logic             qd_hi_zero_ff;
   logic             qd_lo_one_ff;
   logic             take;
   logic             room;
   logic [POS_W:0]   next_sum;

   assign req_chan.ready = ctrl.intake_en;

   always_comb begin
      take     = req_chan.valid && req_chan.ready;
      room     = count_ff < POS_W'(MAX_PACKET_BYTES);
      next_sum = (POS_W+1)'(count_ff) + (POS_W+1)'(req_chan.packet_byte) + (POS_W+1)'(1);

      count_in     = count_ff;
      label_pos_in = label_pos_ff;
      qend_in      = qend_ff;
      term_in      = term_ff;
      err_in       = err_ff;

      if (ctrl.clear) begin
         count_in     = '0;
         label_pos_in = POS_W'(HEADER_BYTES);
         qend_in      = '0;
         term_in      = 1'b0;
         err_in       = 1'b0;
      end else if (take && room) begin
         count_in = count_ff + POS_W'(1);
         if (!term_ff && !err_ff && count_ff == label_pos_ff) begin
            if (req_chan.packet_byte == 8'd0) begin
               term_in = 1'b1;
               qend_in = count_ff + POS_W'(QUESTION_TAIL);
            end else if (req_chan.packet_byte > 8'(LABEL_LIMIT)) begin
               err_in = 1'b1;
            end else begin
               label_pos_in = next_sum[POS_W] ? POS_SATURATE : next_sum[POS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         label_pos_ff <= POS_W'(HEADER_BYTES);
         qend_ff      <= '0;
         term_ff      <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         count_ff     <= count_in;
         label_pos_ff <= label_pos_in;
         qend_ff      <= qend_in;
         term_ff      <= term_in;
         err_ff       <= err_in;
      end
   end

   // Copies of the question count bytes, so that the check needs no store read.
   always_ff @(posedge clock) begin
      if (take && room && count_ff == POS_W'(QDCOUNT_HI_POS)) begin
         qd_hi_zero_ff <= req_chan.packet_byte == 8'd0;
      end
      if (take && room && count_ff == POS_W'(QDCOUNT_LO_POS)) begin
         qd_lo_one_ff <= req_chan.packet_byte == 8'd1;
      end
   end

   assign wr_en   = take && room;
   assign wr_row  = count_ff[ROW_W+2:3];
   assign wr_lane = count_ff[2:0];
   assign wr_data = req_chan.packet_byte;

   assign status.length      = count_ff;
   assign status.final_taken = take && req_chan.final_byte;
   assign status.accept      = term_ff && !err_ff && (qend_ff <= count_ff) &&
                               (count_ff >= POS_W'(HEADER_BYTES)) &&
                               qd_hi_zero_ff && qd_lo_one_ff;

endmodule

// ----- hw/rtl/cdr_reply.sv -----
// Reply sequencer: judges the query and streams the reply out word by word.
module cdr_reply #(
   parameter int MAX_PACKET_BYTES = cdr_pkg::MAX_PACKET_BYTES_DEF,
   localparam int ROWS    = (MAX_PACKET_BYTES + 7) / 8,
   localparam int ROW_W   = $clog2(ROWS),
   localparam int WORDS   = (MAX_PACKET_BYTES + cdr_pkg::ANSWER_BYTES + 7) / 8,
   localparam int WPTR_W  = $clog2(WORDS),
   localparam int TOT_W   = $clog2(WORDS * 8 + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cdr_pkg::parse_status_type status,
   output cdr_pkg::reply_ctrl_type   ctrl,
   input  logic [31:0]               answer_address,
   input  logic [31:0]               answer_ttl,
   output logic                      rd_en,
   output logic [ROW_W-1:0]          rd_row,
   input  logic [63:0]               rd_data,
   cdr_rsp_if.source                 rsp_chan
);
   import cdr_pkg::*;

   reply_state_type   state_ff, state_in;
   logic [WPTR_W-1:0] wptr_ff, wptr_in;
   logic [63:0]       word_ff;
   logic [3:0]        bytes_ff;
   logic              last_ff;
   logic              dropped_ff;
   logic              load_drop;
   logic              load_word;

   logic [TOT_W-1:0]  total;
   logic [TOT_W-1:0]  base;
   logic [TOT_W-1:0]  remain;
   logic [TOT_W-1:0]  len_ext;
   logic [3:0]        word_bytes;
   logic              word_last;
   logic [TOT_W-1:0]  lane_pos [8];
   logic [TOT_W-1:0]  lane_off [8];
   logic [7:0]        lane_byte [8];
   logic [63:0]       word_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      wptr_in        = wptr_ff;
      rd_en          = 1'b0;
      load_drop      = 1'b0;
      load_word      = 1'b0;
      ctrl.intake_en = 1'b0;
      ctrl.clear     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.intake_en = 1'b1;
            if (status.final_taken) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (status.accept) begin
               wptr_in  = '0;
               rd_en    = 1'b1;
               state_in = ST_FETCH;
            end else begin
               load_drop = 1'b1;
               state_in  = ST_SEND;
            end
         end
         ST_FETCH: begin
            load_word = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_chan.ready) begin
               if (last_ff) begin
                  ctrl.clear = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  wptr_in  = wptr_ff + WPTR_W'(1);
                  rd_en    = 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Rows past the stored bytes carry only answer bytes, so any row will do.
      rd_row = (wptr_in < WPTR_W'(ROWS)) ? wptr_in[ROW_W-1:0] : '0;
   end

   // Word assembly: stored bytes with the header rewritten, then the answer record.
   always_comb begin
      len_ext    = TOT_W'(status.length);
      total      = len_ext + TOT_W'(ANSWER_BYTES);
      base       = TOT_W'({wptr_ff, 3'b000});
      remain     = total - base;
      word_bytes = (remain > TOT_W'(8)) ? 4'd8 : remain[3:0];
      word_last  = remain <= TOT_W'(8);
      for (int k = 0; k < 8; k++) begin
         lane_pos[k]  = base + TOT_W'(k);
         lane_off[k]  = lane_pos[k] - len_ext;
         lane_byte[k] = rd_data[63-8*k -: 8];
         if (base == '0) begin
            case (k)
               FLAGS_HI_POS:   lane_byte[k] = FLAGS_HI;
               FLAGS_LO_POS:   lane_byte[k] = FLAGS_LO;
               ANCOUNT_HI_POS: lane_byte[k] = ANCOUNT_HI;
               ANCOUNT_LO_POS: lane_byte[k] = ANCOUNT_LO;
               default: ;
            endcase
         end
         if (lane_pos[k] >= len_ext) begin
            if (lane_pos[k] < total) begin
               lane_byte[k] = answer_byte(lane_off[k][3:0], answer_address, answer_ttl);
            end else begin
               lane_byte[k] = 8'd0;
            end
         end
         word_next[63-8*k -: 8] = lane_byte[k];
      end
   end

   always_ff @(posedge clock) begin
      wptr_ff <= wptr_in;
      if (load_drop) begin
         word_ff    <= '0;
         bytes_ff   <= 4'd0;
         last_ff    <= 1'b1;
         dropped_ff <= 1'b1;
      end else if (load_word) begin
         word_ff    <= word_next;
         bytes_ff   <= word_bytes;
         last_ff    <= word_last;
         dropped_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid         = state_ff == ST_SEND;
   assign rsp_chan.reply_word    = word_ff;
   assign rsp_chan.valid_bytes   = bytes_ff;
   assign rsp_chan.end_of_reply  = last_ff;
   assign rsp_chan.query_dropped = dropped_ff;

endmodule

// ----- hw/rtl/captive_dns_responder.sv -----
// Top level of the captive DNS responder: A-record answers to DNS queries.
//
//   Channel    Direction  Carries
//   req_chan   in         one query byte per item, with a flag on the last byte
//   rsp_chan   out        one reply word per item (up to eight bytes), or a drop item
//   csr_*      in/out     APB-style register port: answer address and answer TTL
//
// Query bytes are taken only while the sequencer is idle. After the final byte, the
// judging state decides on the query; each reply word then passes through a row read
// from the packet store (the fetch state) and the output register (the send state),
// and a drop item is offered right after the judging state. The sequencer fetches a
// row only once the previous word has been taken, so it does not start a new reply
// word while the previous one is still waiting.
// No new byte is taken until the last item of a reply has been taken. Reset is
// synchronous and needs no clearing pass: the store is only read where the current
// datagram wrote it.
module captive_dns_responder #(
   parameter int MAX_PACKET_BYTES = cdr_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   cdr_req_if.sink                        req_chan,
   cdr_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cdr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cdr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cdr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cdr_pkg::*;

   localparam int ROWS  = (MAX_PACKET_BYTES + 7) / 8;
   localparam int ROW_W = $clog2(ROWS);

   // Answer fields; user writes them only while no query is in flight (unenforced).
   logic [31:0] answer_address;
   logic [31:0] answer_ttl;

   // Packet store ports. Writes happen only during intake and reads only during
   // the reply, so the two never touch the same row in the same cycle.
   logic             wr_en;
   logic [ROW_W-1:0] wr_row;
   logic [2:0]       wr_lane;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [ROW_W-1:0] rd_row;
   logic [63:0]      rd_data;

   parse_status_type status;
   reply_ctrl_type   ctrl;

   cdr_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .answer_address (answer_address),
      .answer_ttl     (answer_ttl)
   );

   // The intake writes each byte into its row and lane and follows the labels.
   cdr_parse #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .ctrl     (ctrl),
      .status   (status),
      .wr_en    (wr_en),
      .wr_row   (wr_row),
      .wr_lane  (wr_lane),
      .wr_data  (wr_data)
   );

   cdr_store #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_lane (wr_lane),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   // The sequencer reads one row per reply word, merges the rewritten header and
   // the answer record, and clears the intake state after the last item.
   cdr_reply #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_reply (
      .clock          (clock),
      .reset          (reset),
      .status         (status),
      .ctrl           (ctrl),
      .answer_address (answer_address),
      .answer_ttl     (answer_ttl),
      .rd_en          (rd_en),
      .rd_row         (rd_row),
      .rd_data        (rd_data),
      .rsp_chan       (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // No byte is taken while a reply item is waiting.
   a_no_intake_during_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("query byte taken while a reply item is pending");

   // A drop item is empty and closes the datagram.
   a_drop_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.query_dropped) |->
         (rsp_chan.valid_bytes == 4'd0 && rsp_chan.end_of_reply))
      else $error("malformed drop item");

   // A reply word carries between one and eight bytes.
   a_word_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.query_dropped) |->
         (rsp_chan.valid_bytes != 4'd0 && rsp_chan.valid_bytes <= 4'd8))
      else $error("reply word with a bad byte count");

   // The final byte of a datagram is followed by the judging step, never more intake.
   a_final_stops_intake: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.final_byte) |=> !req_chan.ready)
      else $error("intake still open after the final byte");
`endif

endmodule
